### hw/rtl/rf_sweep_peak_hold_waterfall_unit_macros.svh
// Assertion helpers shared by the sweep unit's modules.
// Each macro expects clk and rst_n in scope.
`ifndef RF_SWEEP_PEAK_HOLD_WATERFALL_UNIT_MACROS_SVH
`define RF_SWEEP_PEAK_HOLD_WATERFALL_UNIT_MACROS_SVH

// Same-cycle implication.
`define RFSPH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfsph check failed");

// Next-cycle implication.
`define RFSPH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfsph check failed");

`endif

### hw/rtl/rfsph_pkg.sv
package rfsph_pkg;

  localparam int DEF_NUM_BINS = 64;
  localparam int DEF_NUM_ROWS = 4;
  localparam int QUEUE_DEPTH  = 2;

  localparam int LEVEL_W   = 10;
  localparam int FREQ_W    = 20;
  localparam int WF_W      = 4;
  localparam int BAND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam int NUM_BANDS = 3;

  localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR  = -10'sd240;
  localparam logic signed [LEVEL_W-1:0] THRESH_RESET = -10'sd116;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_BAND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

  // Band codes; the unused fourth code maps onto the highest band.
  localparam logic [BAND_W-1:0] BAND_LOW  = 2'd0;
  localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
  localparam logic [BAND_W-1:0] BAND_HIGH = 2'd2;

  localparam int START_LOW  = 300000;
  localparam int START_MID  = 400000;
  localparam int START_HIGH = 840000;
  localparam int SPAN_LOW   = 48000;
  localparam int SPAN_MID   = 64000;
  localparam int SPAN_HIGH  = 88000;

  typedef enum logic [1:0] {
    CMD_SAMPLE_TUNED,
    CMD_SAMPLE_UNTUNED,
    CMD_SKIP,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic signed [LEVEL_W-1:0]  rssi;
    logic [FREQ_W-1:0]          freq;
    logic                       done;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  function automatic logic [BAND_W-1:0] band_slot(input logic [BAND_W-1:0] band);
    logic [BAND_W-1:0] res;
    unique case (band)
      BAND_LOW: res = BAND_LOW;
      BAND_MID: res = BAND_MID;
      default:  res = BAND_HIGH;
    endcase
    return res;
  endfunction

endpackage

### hw/rtl/rfsph_queue.sv
module rfsph_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);
  import rfsph_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/rfsph_front.sv
`include "rf_sweep_peak_hold_waterfall_unit_macros.svh"

module rfsph_front #(
  parameter int NUM_BINS = rfsph_pkg::DEF_NUM_BINS,
  parameter int NUM_ROWS = rfsph_pkg::DEF_NUM_ROWS,
  localparam int BIN_W = $clog2(NUM_BINS),
  localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_req_type,
  input  logic signed [rfsph_pkg::LEVEL_W-1:0] in_rssi_level,
  input  logic                                 in_radio_ready,
  input  logic                                 in_tuned_ok,
  input  logic [rfsph_pkg::BAND_W-1:0]         band,
  input  logic                                 sweep_en,
  input  logic                                 q_ready,
  output logic                                 push,
  output rfsph_pkg::cmd_t                      cmd,
  output logic [BIN_W-1:0]                     bin,
  output logic [ROW_W-1:0]                     row
);
  import rfsph_pkg::*;

  localparam int DIV = NUM_BINS - 1;
  localparam int RW  = BIN_W;

  // Per band, span/DIV and span%DIV; the bin frequency offset is built up
  // one bin at a time as quotient plus remainder, so no divider is needed.
  localparam logic [FREQ_W-1:0] STEP_Q [NUM_BANDS] = '{
    FREQ_W'(SPAN_LOW / DIV), FREQ_W'(SPAN_MID / DIV), FREQ_W'(SPAN_HIGH / DIV)
  };
  localparam logic [RW:0] STEP_R [NUM_BANDS] = '{
    (RW+1)'(SPAN_LOW % DIV), (RW+1)'(SPAN_MID % DIV), (RW+1)'(SPAN_HIGH % DIV)
  };
  localparam logic [FREQ_W-1:0] START [NUM_BANDS] = '{
    FREQ_W'(START_LOW), FREQ_W'(START_MID), FREQ_W'(START_HIGH)
  };

  logic [BIN_W-1:0]  cursor_r, cursor_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [FREQ_W-1:0] q_r [NUM_BANDS];
  logic [FREQ_W-1:0] q_nxt [NUM_BANDS];
  logic [RW-1:0]     rem_r [NUM_BANDS];
  logic [RW-1:0]     rem_nxt [NUM_BANDS];
  logic [RW:0]       rem_sum [NUM_BANDS];
  logic [BAND_W-1:0] slot;
  logic              sample, last;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;
  assign sample   = !in_req_type && in_radio_ready && sweep_en;
  assign last     = (cursor_r == BIN_W'(DIV));
  assign slot     = band_slot(band);
  assign bin      = cursor_r;
  assign row      = row_r;

  always_comb begin
    priority if (in_req_type) begin
      cmd.kind = CMD_CLEAR;
    end else if (!(in_radio_ready && sweep_en)) begin
      cmd.kind = CMD_SKIP;
    end else if (in_tuned_ok) begin
      cmd.kind = CMD_SAMPLE_TUNED;
    end else begin
      cmd.kind = CMD_SAMPLE_UNTUNED;
    end
    cmd.rssi = in_rssi_level;
    cmd.freq = START[slot] + q_r[slot];
    cmd.done = sample && last;
  end

  always_comb begin
    cursor_nxt = cursor_r;
    row_nxt    = row_r;
    for (int b = 0; b < NUM_BANDS; b++) begin
      rem_sum[b] = {1'b0, rem_r[b]} + STEP_R[b];
      q_nxt[b]   = q_r[b];
      rem_nxt[b] = rem_r[b];
    end
    if (push && sample) begin
      if (last) begin
        cursor_nxt = '0;
        row_nxt    = (row_r == ROW_W'(NUM_ROWS - 1)) ? '0 : row_r + 1'b1;
        for (int b = 0; b < NUM_BANDS; b++) begin
          q_nxt[b]   = '0;
          rem_nxt[b] = '0;
        end
      end else begin
        cursor_nxt = cursor_r + 1'b1;
        for (int b = 0; b < NUM_BANDS; b++) begin
          if (rem_sum[b] >= (RW+1)'(DIV)) begin
            q_nxt[b]   = q_r[b] + STEP_Q[b] + 1'b1;
            rem_nxt[b] = RW'(rem_sum[b] - (RW+1)'(DIV));
          end else begin
            q_nxt[b]   = q_r[b] + STEP_Q[b];
            rem_nxt[b] = RW'(rem_sum[b]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      row_r    <= '0;
      for (int b = 0; b < NUM_BANDS; b++) begin
        q_r[b]   <= '0;
        rem_r[b] <= '0;
      end
    end else begin
      cursor_r <= cursor_nxt;
      row_r    <= row_nxt;
      for (int b = 0; b < NUM_BANDS; b++) begin
        q_r[b]   <= q_nxt[b];
        rem_r[b] <= rem_nxt[b];
      end
    end
  end

  `RFSPH_ASSERT_NXT(a_done_wraps_cursor, push && cmd.done, cursor_r == '0)
  `RFSPH_ASSERT_NXT(a_hold_without_sample, push && !sample, $stable(cursor_r) && $stable(row_r))
  `RFSPH_ASSERT_IMP(a_origin_offsets_zero, cursor_r == '0, q_r[0] == '0 && q_r[1] == '0 && q_r[2] == '0)

endmodule

### hw/rtl/rfsph_back.sv
`include "rf_sweep_peak_hold_waterfall_unit_macros.svh"

module rfsph_back #(
  parameter int NUM_BINS = rfsph_pkg::DEF_NUM_BINS,
  parameter int NUM_ROWS = rfsph_pkg::DEF_NUM_ROWS,
  localparam int BIN_W = $clog2(NUM_BINS),
  localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  output logic                                 q_pop,
  input  rfsph_pkg::cmd_t                      q_cmd,
  input  logic [BIN_W-1:0]                     q_bin,
  input  logic [ROW_W-1:0]                     q_row,
  input  logic signed [rfsph_pkg::LEVEL_W-1:0] thresh,
  input  logic                                 band_clr,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [BIN_W-1:0]                     out_bin_index,
  output logic [rfsph_pkg::FREQ_W-1:0]         out_bin_freq_khz,
  output logic signed [rfsph_pkg::LEVEL_W-1:0] out_level_out,
  output logic signed [rfsph_pkg::LEVEL_W-1:0] out_peak_out,
  output logic [rfsph_pkg::WF_W-1:0]           out_waterfall_value,
  output logic [ROW_W-1:0]                     out_waterfall_row,
  output logic signed [rfsph_pkg::LEVEL_W-1:0] out_strongest_level,
  output logic [rfsph_pkg::FREQ_W-1:0]         out_strongest_freq_khz,
  output logic                                 out_sweep_done,
  output logic                                 out_strong_signal
);
  import rfsph_pkg::*;

  // Integer dBm (halved toward zero), then (d+110)/5 limited to 0..15.
  // x/5 for x below 75 is x*205>>10.
  function automatic logic [WF_W-1:0] quantize(input logic signed [LEVEL_W-1:0] lvl);
    logic signed [LEVEL_W:0] t;
    logic signed [LEVEL_W:0] x;
    logic [14:0]             prod;
    logic [WF_W-1:0]         res;
    t = {lvl[LEVEL_W-1], lvl} + {{LEVEL_W{1'b0}}, lvl[LEVEL_W-1]};
    x = (t >>> 1) + 11'sd110;
    prod = 15'(x[6:0]) * 15'd205;
    if (x <= 11'sd0) begin
      res = '0;
    end else if (x >= 11'sd75) begin
      res = WF_W'(15);
    end else begin
      res = prod[13:10];
    end
    return res;
  endfunction

  logic signed [LEVEL_W-1:0] lvl_mem [NUM_BINS];
  logic signed [LEVEL_W-1:0] pk_mem  [NUM_BINS];

  logic                      a_valid_r, a_valid_nxt;
  cmd_t                      a_cmd_r;
  logic [BIN_W-1:0]          a_bin_r;
  logic [ROW_W-1:0]          a_row_r;
  logic signed [LEVEL_W-1:0] lvl_rd_r, pk_rd_r;

  logic [NUM_BINS-1:0]       lvl_vld_r, lvl_vld_nxt;
  logic [NUM_BINS-1:0]       pk_vld_r, pk_vld_nxt;
  logic signed [LEVEL_W-1:0] best_lvl_r, best_lvl_nxt;
  logic [FREQ_W-1:0]         best_freq_r, best_freq_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic                      a_move, tuned, visit, pk_wr;
  logic signed [LEVEL_W-1:0] lvl_cur, pk_cur, lvl_new, pk_new;

  assign a_move    = a_valid_r && (!out_valid_r || out_ready);
  assign q_pop     = q_valid && (!a_valid_r || a_move);
  assign out_valid = out_valid_r;

  // Entries never written since reset, or peaks since the last clear,
  // read as the floor level.
  assign lvl_cur = lvl_vld_r[a_bin_r] ? lvl_rd_r : LEVEL_FLOOR;
  assign pk_cur  = pk_vld_r[a_bin_r] ? pk_rd_r : LEVEL_FLOOR;
  assign tuned   = (a_cmd_r.kind == CMD_SAMPLE_TUNED);
  assign visit   = tuned || (a_cmd_r.kind == CMD_SAMPLE_UNTUNED);
  assign pk_wr   = tuned && (a_cmd_r.rssi > pk_cur);

  always_comb begin
    lvl_new       = lvl_cur;
    pk_new        = pk_cur;
    best_lvl_nxt  = best_lvl_r;
    best_freq_nxt = best_freq_r;
    lvl_vld_nxt   = lvl_vld_r;
    pk_vld_nxt    = pk_vld_r;
    if (a_move) begin
      unique case (a_cmd_r.kind)
        CMD_SAMPLE_TUNED: begin
          lvl_new = a_cmd_r.rssi;
          lvl_vld_nxt[a_bin_r] = 1'b1;
          if (pk_wr) begin
            pk_new = a_cmd_r.rssi;
            pk_vld_nxt[a_bin_r] = 1'b1;
          end
          if (a_cmd_r.rssi > best_lvl_r) begin
            best_lvl_nxt  = a_cmd_r.rssi;
            best_freq_nxt = a_cmd_r.freq;
          end
        end
        CMD_CLEAR: begin
          pk_new        = LEVEL_FLOOR;
          pk_vld_nxt    = '0;
          best_lvl_nxt  = LEVEL_FLOOR;
          best_freq_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    if (band_clr) begin
      pk_vld_nxt    = '0;
      best_lvl_nxt  = LEVEL_FLOOR;
      best_freq_nxt = '0;
    end
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (q_pop) begin
      a_valid_nxt = 1'b1;
    end else if (a_move) begin
      a_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (a_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      lvl_vld_r   <= '0;
      pk_vld_r    <= '0;
      best_lvl_r  <= LEVEL_FLOOR;
      best_freq_r <= '0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_vld_r   <= lvl_vld_nxt;
      pk_vld_r    <= pk_vld_nxt;
      best_lvl_r  <= best_lvl_nxt;
      best_freq_r <= best_freq_nxt;
    end
  end

  // Read at pop, write when the same item leaves the stage. Consecutive
  // items never share a bin once a sample has advanced the cursor.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_cmd_r  <= q_cmd;
      a_bin_r  <= q_bin;
      a_row_r  <= q_row;
      lvl_rd_r <= lvl_mem[q_bin];
      pk_rd_r  <= pk_mem[q_bin];
    end
    if (a_move && tuned) begin
      lvl_mem[a_bin_r] <= a_cmd_r.rssi;
    end
    if (a_move && pk_wr) begin
      pk_mem[a_bin_r] <= a_cmd_r.rssi;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      out_bin_index          <= a_bin_r;
      out_bin_freq_khz       <= a_cmd_r.freq;
      out_level_out          <= lvl_new;
      out_peak_out           <= pk_new;
      out_waterfall_value    <= visit ? quantize(lvl_new) : '0;
      out_waterfall_row      <= a_row_r;
      out_strongest_level    <= best_lvl_nxt;
      out_strongest_freq_khz <= best_freq_nxt;
      out_sweep_done         <= a_cmd_r.done;
      out_strong_signal      <= a_cmd_r.done && (best_lvl_nxt > thresh);
    end
  end

  `RFSPH_ASSERT_IMP(a_no_rmw_clash, a_move && q_pop && tuned, q_bin != a_bin_r)
  `RFSPH_ASSERT_NXT(a_clear_resets_best, a_move && a_cmd_r.kind == CMD_CLEAR, best_lvl_r == LEVEL_FLOOR && best_freq_r == '0)
  `RFSPH_ASSERT_NXT(a_peak_covers_level, a_move && tuned, out_peak_out >= out_level_out)

endmodule

### hw/rtl/rf_sweep_peak_hold_waterfall_unit.sv
// Sweeping spectrum analyzer core: one RSSI sample per input word, one result
// word per input word, in order. A front stage classifies each word, steps the
// bin cursor, waterfall row and bin frequency, and queues a command in a
// two-entry queue; a back stage reads the bin's level and peak from two
// memories with one read port and one write port each, updates them with peak
// hold and the strongest level, and loads the output register. Sustained rate
// is one word per clock while the output is not stalled, set by the one
// read-modify-write of the level and peak memories per word; a result passes
// through the queue, the back stage's read registers and the output register.
// Reset takes effect at once: per-bin valid flops make unwritten levels and
// cleared peaks read as -120 dBm, so there is no clearing pass. A band change
// or a clear word wipes all peaks and the strongest level.
// Configuration writes are expected only while the unit is idle.
module rf_sweep_peak_hold_waterfall_unit #(
  parameter int NUM_BINS = rfsph_pkg::DEF_NUM_BINS,
  parameter int NUM_ROWS = rfsph_pkg::DEF_NUM_ROWS,
  localparam int BIN_W = $clog2(NUM_BINS),
  localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [rfsph_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [rfsph_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_req_type,
  input  logic signed [rfsph_pkg::LEVEL_W-1:0]    in_rssi_level,
  input  logic                                    in_radio_ready,
  input  logic                                    in_tuned_ok,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [BIN_W-1:0]                        out_bin_index,
  output logic [rfsph_pkg::FREQ_W-1:0]            out_bin_freq_khz,
  output logic signed [rfsph_pkg::LEVEL_W-1:0]    out_level_out,
  output logic signed [rfsph_pkg::LEVEL_W-1:0]    out_peak_out,
  output logic [rfsph_pkg::WF_W-1:0]              out_waterfall_value,
  output logic [ROW_W-1:0]                        out_waterfall_row,
  output logic signed [rfsph_pkg::LEVEL_W-1:0]    out_strongest_level,
  output logic [rfsph_pkg::FREQ_W-1:0]            out_strongest_freq_khz,
  output logic                                    out_sweep_done,
  output logic                                    out_strong_signal
);
  import rfsph_pkg::*;

  localparam int QW = CMD_W + BIN_W + ROW_W;

  logic [BAND_W-1:0]         band_r, band_nxt;
  logic                      sweep_en_r, sweep_en_nxt;
  logic signed [LEVEL_W-1:0] thresh_r, thresh_nxt;
  logic                      band_clr;

  logic                      push, q_ready, q_valid, q_pop;
  cmd_t                      f_cmd, q_cmd;
  logic [BIN_W-1:0]          f_bin, q_bin;
  logic [ROW_W-1:0]          f_row, q_row;
  logic [QW-1:0]             q_data;

  always_comb begin
    band_nxt     = band_r;
    sweep_en_nxt = sweep_en_r;
    thresh_nxt   = thresh_r;
    band_clr     = 1'b0;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_BAND: begin
          band_nxt = cfg_wdata[BAND_W-1:0];
          band_clr = (cfg_wdata[BAND_W-1:0] != band_r);
        end
        CFG_ENABLE: sweep_en_nxt = cfg_wdata[0];
        CFG_THRESH: thresh_nxt   = cfg_wdata[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r     <= BAND_LOW;
      sweep_en_r <= 1'b0;
      thresh_r   <= THRESH_RESET;
    end else begin
      band_r     <= band_nxt;
      sweep_en_r <= sweep_en_nxt;
      thresh_r   <= thresh_nxt;
    end
  end

  rfsph_front #(
    .NUM_BINS (NUM_BINS),
    .NUM_ROWS (NUM_ROWS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_rssi_level  (in_rssi_level),
    .in_radio_ready (in_radio_ready),
    .in_tuned_ok    (in_tuned_ok),
    .band           (band_r),
    .sweep_en       (sweep_en_r),
    .q_ready        (q_ready),
    .push           (push),
    .cmd            (f_cmd),
    .bin            (f_bin),
    .row            (f_row)
  );

  rfsph_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({f_cmd, f_bin, f_row}),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_data   (q_data),
    .pop_valid  (q_valid)
  );

  assign q_cmd = cmd_t'(q_data[QW-1 -: CMD_W]);
  assign q_bin = q_data[BIN_W+ROW_W-1 -: BIN_W];
  assign q_row = q_data[ROW_W-1:0];

  rfsph_back #(
    .NUM_BINS (NUM_BINS),
    .NUM_ROWS (NUM_ROWS)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_valid                (q_valid),
    .q_pop                  (q_pop),
    .q_cmd                  (q_cmd),
    .q_bin                  (q_bin),
    .q_row                  (q_row),
    .thresh                 (thresh_r),
    .band_clr               (band_clr),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_bin_index          (out_bin_index),
    .out_bin_freq_khz       (out_bin_freq_khz),
    .out_level_out          (out_level_out),
    .out_peak_out           (out_peak_out),
    .out_waterfall_value    (out_waterfall_value),
    .out_waterfall_row      (out_waterfall_row),
    .out_strongest_level    (out_strongest_level),
    .out_strongest_freq_khz (out_strongest_freq_khz),
    .out_sweep_done         (out_sweep_done),
    .out_strong_signal      (out_strong_signal)
  );

endmodule

### verif/rf_sweep_peak_hold_waterfall_unit_tb.sv
module rf_sweep_peak_hold_waterfall_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfsph_pkg::*;

  localparam int NUM_BINS = DEF_NUM_BINS;
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef struct packed {
    logic [5:0]                bin;
    logic [FREQ_W-1:0]         freq;
    logic signed [LEVEL_W-1:0] level;
    logic signed [LEVEL_W-1:0] peak;
    logic [WF_W-1:0]           wf_value;
    logic [1:0]                wf_row;
    logic signed [LEVEL_W-1:0] top_level;
    logic [FREQ_W-1:0]         top_freq;
    logic                      done;
    logic                      strong_sig;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic in_req_type;
  logic signed [LEVEL_W-1:0] in_rssi_level;
  logic in_radio_ready;
  logic in_tuned_ok;
  logic out_valid;
  logic out_ready;
  logic [5:0] out_bin_index;
  logic [FREQ_W-1:0] out_bin_freq_khz;
  logic signed [LEVEL_W-1:0] out_level_out;
  logic signed [LEVEL_W-1:0] out_peak_out;
  logic [WF_W-1:0] out_waterfall_value;
  logic [1:0] out_waterfall_row;
  logic signed [LEVEL_W-1:0] out_strongest_level;
  logic [FREQ_W-1:0] out_strongest_freq_khz;
  logic out_sweep_done;
  logic out_strong_signal;

  // Shadow copy of the sweep state and registers.
  logic [BAND_W-1:0] cur_band;
  logic sweep_on;
  int strong_thr;
  int unsigned sweep_cursor;
  int level_mem [NUM_BINS];
  int peak_mem [NUM_BINS];
  int top_level;
  int unsigned top_freq;
  logic [1:0] wf_row;

  bin_result_t pending_bins[$];
  int fail_count = 0;
  bit idle_on = 1'b1;
  int hold_req = 0;

  rf_sweep_peak_hold_waterfall_unit i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_idx                (cfg_idx),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_req_type            (in_req_type),
    .in_rssi_level          (in_rssi_level),
    .in_radio_ready         (in_radio_ready),
    .in_tuned_ok            (in_tuned_ok),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_bin_index          (out_bin_index),
    .out_bin_freq_khz       (out_bin_freq_khz),
    .out_level_out          (out_level_out),
    .out_peak_out           (out_peak_out),
    .out_waterfall_value    (out_waterfall_value),
    .out_waterfall_row      (out_waterfall_row),
    .out_strongest_level    (out_strongest_level),
    .out_strongest_freq_khz (out_strongest_freq_khz),
    .out_sweep_done         (out_sweep_done),
    .out_strong_signal      (out_strong_signal)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void wipe_peaks();
    for (int i = 0; i < NUM_BINS; i++) begin
      peak_mem[i] = LEVEL_FLOOR;
    end
    top_level = LEVEL_FLOOR;
    top_freq = 0;
  endfunction

  function automatic void reset_shadow();
    cur_band = BAND_LOW;
    sweep_on = 1'b0;
    strong_thr = THRESH_RESET;
    sweep_cursor = 0;
    wf_row = '0;
    for (int i = 0; i < NUM_BINS; i++) begin
      level_mem[i] = LEVEL_FLOOR;
    end
    wipe_peaks();
  endfunction

  function automatic bin_result_t predict_bin_result(input logic req,
      input logic signed [LEVEL_W-1:0] rssi, input logic rdy, input logic tuned);
    bin_result_t r;
    int unsigned slot;
    int unsigned start_khz;
    int unsigned span_khz;
    int unsigned freq;
    int dbm;
    int q;
    slot = sweep_cursor;
    case (cur_band)
      BAND_LOW: begin
        start_khz = START_LOW;
        span_khz = SPAN_LOW;
      end
      BAND_MID: begin
        start_khz = START_MID;
        span_khz = SPAN_MID;
      end
      default: begin
        start_khz = START_HIGH;
        span_khz = SPAN_HIGH;
      end
    endcase
    freq = start_khz + span_khz * slot / (NUM_BINS - 1);
    r = '0;
    r.bin = 6'(slot);
    r.freq = FREQ_W'(freq);
    r.wf_row = wf_row;
    if (req == REQ_CLEAR) begin
      wipe_peaks();
    end else if (rdy && sweep_on) begin
      if (tuned) begin
        level_mem[slot] = int'(rssi);
        if (int'(rssi) > peak_mem[slot]) peak_mem[slot] = int'(rssi);
        // Equal levels keep the earlier frequency.
        if (int'(rssi) > top_level) begin
          top_level = int'(rssi);
          top_freq = freq;
        end
      end
      dbm = level_mem[slot] / 2;
      if (dbm <= -110) begin
        q = 0;
      end else begin
        q = (dbm + 110) * 15 / 75;
        if (q > 15) q = 15;
      end
      r.wf_value = WF_W'(q);
      if (slot == NUM_BINS - 1) begin
        sweep_cursor = 0;
        wf_row = wf_row + 2'd1;
        r.done = 1'b1;
        r.strong_sig = top_level > strong_thr;
      end else begin
        sweep_cursor = slot + 1;
      end
    end
    r.level = LEVEL_W'(level_mem[slot]);
    r.peak = LEVEL_W'(peak_mem[slot]);
    r.top_level = LEVEL_W'(top_level);
    r.top_freq = FREQ_W'(top_freq);
    return r;
  endfunction

  function automatic string show_result(input bin_result_t r);
    return $sformatf({"bin=%0d freq=%0d lvl=%0d peak=%0d wf=%0d row=%0d top=%0d",
                      " topf=%0d done=%0b strong_sig=%0b"},
                     r.bin, r.freq, r.level, r.peak, r.wf_value, r.wf_row, r.top_level,
                     r.top_freq, r.done, r.strong_sig);
  endfunction

  function automatic logic signed [LEVEL_W-1:0] rand_level();
    int v;
    // Mostly levels in the usable range, sometimes any 10-bit pattern.
    if ($urandom_range(9) == 0) return LEVEL_W'($urandom_range(1023));
    v = $urandom_range(260);
    return LEVEL_W'(-v);
  endfunction

  task automatic send_word(input logic req, input logic signed [LEVEL_W-1:0] rssi,
                           input logic rdy, input logic tuned);
    if (idle_on && $urandom_range(99) < 6) begin
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req_type = req;
    in_rssi_level = rssi;
    in_radio_ready = rdy;
    in_tuned_ok = tuned;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_bins.push_back(predict_bin_result(req, rssi, rdy, tuned));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_random_word();
    int pick;
    logic signed [LEVEL_W-1:0] lv;
    pick = $urandom_range(99);
    lv = rand_level();
    if (pick < 3) send_word(REQ_CLEAR, lv, 1'($urandom_range(1)), 1'($urandom_range(1)));
    else if (pick < 8) send_word(REQ_SAMPLE, lv, 1'b0, 1'($urandom_range(1)));
    else if (pick < 15) send_word(REQ_SAMPLE, lv, 1'b1, 1'b0);
    else send_word(REQ_SAMPLE, lv, 1'b1, 1'b1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    // Registers only change while nothing is in flight.
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = CFG_DATA_W'(data);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_BAND: begin
        if (cfg_wdata[BAND_W-1:0] != cur_band) begin
          cur_band = cfg_wdata[BAND_W-1:0];
          wipe_peaks();
        end
      end
      CFG_ENABLE: sweep_on = cfg_wdata[0];
      CFG_THRESH: strong_thr = $signed(cfg_wdata);
      default: ;
    endcase
  endtask

  task automatic run_sweep(input int lo, input int hi);
    do begin
      send_word(REQ_SAMPLE, LEVEL_W'(-$urandom_range(-hi, -lo)), 1'b1,
                $urandom_range(7) != 0);
    end while (sweep_cursor != 0);
  endtask

  task automatic test_paused_and_clear();
    send_word(REQ_SAMPLE, -10'sd20, 1'b1, 1'b1);
    send_word(REQ_SAMPLE, 10'sd0, 1'b1, 1'b0);
    send_word(REQ_CLEAR, -10'sd260, 1'b1, 1'b1);
    write_reg(CFG_ENABLE, 1);
  endtask

  task automatic test_field_extremes();
    send_word(REQ_SAMPLE, -10'sd260, 1'b1, 1'b1);
    send_word(REQ_SAMPLE, 10'sd0, 1'b1, 1'b1);
    send_word(REQ_SAMPLE, -10'sd512, 1'b1, 1'b1);
    send_word(REQ_SAMPLE, 10'sd511, 1'b1, 1'b1);
    send_word(REQ_SAMPLE, -10'sd1, 1'b1, 1'b1);
    // Around the bottom of the waterfall scale.
    send_word(REQ_SAMPLE, -10'sd221, 1'b1, 1'b1);
    send_word(REQ_SAMPLE, -10'sd220, 1'b1, 1'b1);
    send_word(REQ_SAMPLE, -10'sd219, 1'b1, 1'b1);
    send_word(REQ_SAMPLE, -10'sd210, 1'b1, 1'b1);
    send_word(REQ_SAMPLE, -10'sd71, 1'b1, 1'b1);
    send_word(REQ_SAMPLE, -10'sd70, 1'b1, 1'b1);
    send_word(REQ_SAMPLE, -10'sd30, 1'b0, 1'b1);
    send_word(REQ_SAMPLE, -10'sd30, 1'b0, 1'b0);
    send_word(REQ_SAMPLE, -10'sd40, 1'b1, 1'b0);
    send_word(REQ_CLEAR, 10'sd0, 1'b0, 1'b0);
    send_word(REQ_SAMPLE, -10'sd100, 1'b1, 1'b1);
    send_word(REQ_SAMPLE, -10'sd100, 1'b1, 1'b1);
    send_word(REQ_SAMPLE, -10'sd101, 1'b1, 1'b1);
    send_word(REQ_SAMPLE, -10'sd99, 1'b1, 1'b1);
  endtask

  task automatic test_sweep_thresholds();
    write_reg(CFG_THRESH, -512);
    run_sweep(-260, 0);
    write_reg(CFG_THRESH, 511);
    run_sweep(-260, 0);
    write_reg(CFG_THRESH, 0);
    run_sweep(-260, 0);
    // Nothing rises above the floor, so the strongest level ties the threshold.
    write_reg(CFG_THRESH, -240);
    send_word(REQ_CLEAR, 10'sd0, 1'b1, 1'b1);
    run_sweep(-260, -241);
    write_reg(CFG_THRESH, -260);
    run_sweep(-260, -150);
    write_reg(CFG_THRESH, -116);
    run_sweep(-260, 0);
  endtask

  task automatic test_band_changes();
    for (int b = 3; b >= 0; b--) begin
      write_reg(CFG_BAND, b);
      repeat (20) send_word(REQ_SAMPLE, rand_level(), 1'b1, 1'b1);
      write_reg(CFG_BAND, b);
      repeat (10) send_random_word();
    end
    write_reg(CFG_BAND, 3);
    run_sweep(-260, 0);
  endtask

  task automatic test_output_stall();
    hold_req = 300;
    repeat (40) send_random_word();
    hold_req = 500;
    repeat (60) send_word(REQ_SAMPLE, rand_level(), 1'b1, 1'b1);
  endtask

  task automatic test_random_traffic();
    idle_on = 1'b0;
    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 1) idle_on = 1'b1;
      repeat (155) send_random_word();
      write_reg(CFG_BAND, $urandom_range(3));
      write_reg(CFG_THRESH, ($urandom_range(3) == 0) ? $urandom_range(1023)
                                                      : -$urandom_range(260));
      if (phase == 3) begin
        // A short paused stretch; of these words only clears change the state.
        write_reg(CFG_ENABLE, 0);
        repeat (20) send_random_word();
        write_reg(CFG_ENABLE, 1);
      end
    end
  endtask

  // Result side: random stalls plus requested long hold-offs.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = !(idle_on && $urandom_range(99) < 6);
      end
    end
  end

  always @(posedge clk) begin
    bin_result_t seen;
    bin_result_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_bin_index, out_bin_freq_khz, out_level_out, out_peak_out,
              out_waterfall_value, out_waterfall_row, out_strongest_level,
              out_strongest_freq_khz, out_sweep_done, out_strong_signal};
      if (pending_bins.size() == 0) begin
        if (fail_count < 10) $display("ERROR: unexpected result word %s", show_result(seen));
        fail_count++;
      end else begin
        want = pending_bins.pop_front();
        if (seen !== want) begin
          if (fail_count < 10) begin
            $display("ERROR: result mismatch at %0t", $realtime);
            $display("  expected %s", show_result(want));
            $display("  actual   %s", show_result(seen));
          end
          fail_count++;
        end
      end
    end
  end

  initial begin
    int waited;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_req_type = REQ_SAMPLE;
    in_rssi_level = '0;
    in_radio_ready = 1'b0;
    in_tuned_ok = 1'b0;
    reset_shadow();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_paused_and_clear();
    test_field_extremes();
    test_sweep_thresholds();
    test_band_changes();
    test_output_stall();
    test_random_traffic();

    waited = 0;
    while (pending_bins.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_bins.size() != 0) begin
      $display("ERROR: %0d result words never arrived", pending_bins.size());
      fail_count += pending_bins.size();
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
